>>> sv/linear_probe_hash_map_core_assert.svh
// assertion macros for the hash map core
`ifndef LINEAR_PROBE_HASH_MAP_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_CORE_ASSERT_SVH

// checked only outside reset
`define LPHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define LPHM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> sv/lphm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lphm_pkg;

  localparam int unsigned SLOTS   = 1024;
  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned CNT_W   = SLOT_W + 1;
  localparam int unsigned MAX_W   = 10;
  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(716);
  localparam logic [31:0] MIX_C1  = 32'h7feb352d;
  localparam logic [31:0] MIX_C2  = 32'h846ca68b;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_FIND   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_PROBE,
    BK_CLEAR,
    BK_RESP
  } bk_state_e;

  // classified item handed from front to back
  typedef struct packed {
    kind_e             kind;
    logic [31:0]       key;
    logic [31:0]       value;
    logic [SLOT_W-1:0] home;
  } item_t;

endpackage
`default_nettype wire

>>> sv/lphm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module lphm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [1:0]    in_kind_i,
  input  wire logic [31:0]   in_key_i,
  input  wire logic [31:0]   in_value_i,
  output logic               push_o,
  input  wire logic          full_i,
  output lphm_pkg::item_t    item_o
);
  import lphm_pkg::*;

  logic        s1_v_q, s2_v_q;
  logic [1:0]  s1_kind_q, s2_kind_q;
  logic [31:0] s1_key_q, s2_key_q, s1_val_q, s2_val_q;
  logic [31:0] s1_p_q, s2_p_q;
  logic [31:0] x1, x2, h;
  logic        adv;

  assign adv        = !s2_v_q || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = s2_v_q && !full_i;

  assign x1 = in_key_i ^ (in_key_i >> 16);
  assign x2 = s1_p_q ^ (s1_p_q >> 15);
  assign h  = s2_p_q ^ (s2_p_q >> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
    end
  end

  // first and second multiply of the mix, one per stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_kind_q <= in_kind_i;
      s1_key_q  <= in_key_i;
      s1_val_q  <= in_value_i;
      s1_p_q    <= x1 * MIX_C1;
      s2_kind_q <= s1_kind_q;
      s2_key_q  <= s1_key_q;
      s2_val_q  <= s1_val_q;
      s2_p_q    <= x2 * MIX_C2;
    end
  end

  always_comb begin
    item_o.kind  = kind_e'(s2_kind_q);
    item_o.key   = s2_key_q;
    item_o.value = s2_val_q;
    item_o.home  = h[SLOT_W-1:0];
  end

endmodule
`default_nettype wire

>>> sv/lphm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module lphm_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire lphm_pkg::item_t  item_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output lphm_pkg::item_t       item_o
);
  import lphm_pkg::*;

  item_t      buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = buf_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wp_q] <= item_i;
  end

endmodule
`default_nettype wire

>>> sv/lphm_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "linear_probe_hash_map_core_assert.svh"
module lphm_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [lphm_pkg::MAX_W-1:0] max_i,
  input  wire logic                      valid_i,
  input  wire lphm_pkg::item_t           item_i,
  output logic                           pop_o,
  output logic                           init_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [2:0]                     out_status_o,
  output logic [31:0]                    out_found_value_o
);
  import lphm_pkg::*;

  localparam logic [SLOT_W-1:0] LAST = '1;

  bk_state_e         state_q, state_d;
  item_t             op_q, op_d;
  logic [SLOT_W-1:0] pos_q, pos_d, n_q, n_d, swp_q, swp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  status_e           res_st_q, res_st_d;
  logic [31:0]       res_val_q, res_val_d;
  logic              ov_q, ov_d;
  status_e           os_q, os_d;
  logic [31:0]       ofv_q, ofv_d;

  // slot memory: used, key, value
  logic [64:0]       mem_q [SLOTS];
  logic [64:0]       rdata_q, wd;
  logic              rd_en, we;
  logic [SLOT_W-1:0] rd_addr, wa;
  logic              hit_key, is_ins;

  always_ff @(posedge clk_i) begin
    if (we)    mem_q[wa] <= wd;
    if (rd_en) rdata_q   <= mem_q[rd_addr];
  end

  assign hit_key = (rdata_q[63:32] == op_q.key);
  assign is_ins  = (op_q.kind == KIND_INSERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      swp_q   <= '0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      swp_q   <= swp_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    pos_q     <= pos_d;
    n_q       <= n_d;
    res_st_q  <= res_st_d;
    res_val_q <= res_val_d;
    os_q      <= os_d;
    ofv_q     <= ofv_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pos_d     = pos_q;
    n_d       = n_q;
    swp_d     = swp_q;
    cnt_d     = cnt_q;
    res_st_d  = res_st_q;
    res_val_d = res_val_q;
    ov_d      = ov_q && out_stall_i;
    os_d      = os_q;
    ofv_d     = ofv_q;
    pop_o     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = pos_q + SLOT_W'(1);
    we        = 1'b0;
    wa        = swp_q;
    wd        = '0;
    unique case (state_q)
      BK_INIT, BK_CLEAR: begin
        we    = 1'b1;
        swp_d = swp_q + SLOT_W'(1);
        if (swp_q == LAST) begin
          if (state_q == BK_INIT) begin
            state_d = BK_IDLE;
          end else begin
            res_st_d = ST_CLEARED;
            state_d  = BK_RESP;
          end
        end
      end
      BK_IDLE: begin
        if (valid_i) begin
          pop_o     = 1'b1;
          op_d      = item_i;
          res_val_d = '0;
          unique case (item_i.kind)
            KIND_INSERT, KIND_FIND: begin
              rd_en   = 1'b1;
              rd_addr = item_i.home;
              pos_d   = item_i.home;
              n_d     = '0;
              state_d = BK_PROBE;
            end
            KIND_CLEAR: begin
              swp_d   = '0;
              cnt_d   = '0;
              state_d = BK_CLEAR;
            end
            default: begin
              res_st_d = ST_NOT_FOUND;
              state_d  = BK_RESP;
            end
          endcase
        end
      end
      BK_PROBE: begin
        priority if (!rdata_q[64]) begin
          state_d = BK_RESP;
          if (!is_ins) begin
            res_st_d = ST_NOT_FOUND;
          end else if (cnt_q >= CNT_W'(max_i)) begin
            res_st_d = ST_FULL;
          end else begin
            we       = 1'b1;
            wa       = pos_q;
            wd       = {1'b1, op_q.key, op_q.value};
            cnt_d    = cnt_q + CNT_W'(1);
            res_st_d = ST_INSERTED;
          end
        end else if (hit_key) begin
          state_d = BK_RESP;
          if (is_ins) begin
            res_st_d = ST_DUPLICATE;
          end else begin
            res_st_d  = ST_FOUND;
            res_val_d = rdata_q[31:0];
          end
        end else if (n_q == LAST) begin
          state_d  = BK_RESP;
          res_st_d = is_ins ? ST_FULL : ST_NOT_FOUND;
        end else begin
          rd_en = 1'b1;
          pos_d = pos_q + SLOT_W'(1);
          n_d   = n_q + SLOT_W'(1);
        end
      end
      BK_RESP: begin
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          os_d    = res_st_q;
          ofv_d   = res_val_q;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign init_o            = (state_q == BK_INIT);
  assign out_valid_o       = ov_q;
  assign out_status_o      = os_q;
  assign out_found_value_o = ofv_q;

  `LPHM_ASSERT_ALWAYS(a_cnt_range, (cnt_q <= CNT_W'(SLOTS)), "entry count above capacity")
  `LPHM_ASSERT(a_probe_write_insert, (we && state_q == BK_PROBE) |-> is_ins,
               "slot written by a non-insert probe")
  `LPHM_ASSERT(a_clear_zero, (state_q == BK_CLEAR) |-> (cnt_q == '0),
               "count not zero during clear")
  `LPHM_ASSERT(a_init_no_pop, (state_q == BK_INIT) |-> !pop_o, "queue popped during init")

endmodule
`default_nettype wire

>>> sv/linear_probe_hash_map_core.sv
`timescale 1ns / 1ps
`default_nettype none
// an item passes the hash stages, the queue, a probe of each slot from its home slot on, and
//   the response register; the back end finishes one item before it pops the next
// probe rate is set by the single read port of the slot memory (one slot per cycle)
// clear-all sweeps every slot of the slot memory
// reset: async active low; a clearing pass over every slot follows, inputs stalled meanwhile
// max_entries resets to 716
module linear_probe_hash_map_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [9:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  in_kind_i,
  input  wire logic [31:0] in_key_i,
  input  wire logic [31:0] in_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       out_status_o,
  output logic [31:0]      out_found_value_o
);
  import lphm_pkg::*;

  // load limit register
  logic [MAX_W-1:0] max_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  logic  front_stall, init, push, full, pop, q_valid;
  item_t f_item, q_item;

  // no transfer accepted while the slot memory is being cleared after reset
  assign in_stall_o = front_stall || init;

  lphm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i && !init),
    .in_stall_o (front_stall),
    .in_kind_i  (in_kind_i),
    .in_key_i   (in_key_i),
    .in_value_i (in_value_i),
    .push_o     (push),
    .full_i     (full),
    .item_o     (f_item)
  );

  // short queue decouples hashing from probing
  lphm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  lphm_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .max_i             (max_q),
    .valid_i           (q_valid),
    .item_i            (q_item),
    .pop_o             (pop),
    .init_o            (init),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_status_o      (out_status_o),
    .out_found_value_o (out_found_value_o)
  );

endmodule
`default_nettype wire
